>>> hw/rtl/gds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gds_pkg
// shared widths, constants, month table and control types of the date shifter
// ----------------------------------------------------------------------------
package gds_pkg;

   localparam int YEAR_W  = 16;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int CNT_W   = 16;
   localparam int ACC_W   = 18;   // signed day accumulator, day +/- count
   localparam int REM_W   = 7;    // year mod 100
   localparam int PROD_W  = 29;   // year * reciprocal of 100
   localparam int RECIP_SHIFT = 19;
   localparam int QUOT_W  = 10;   // year / 100

   localparam logic [12:0]        RECIP_100      = 13'd5243;
   localparam logic [YEAR_W-1:0]  MIN_YEAR_RESET = 16'd1601;
   localparam logic [YEAR_W-1:0]  YEAR_LAST      = 16'hFFFF;
   localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST      = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_LAST_DEC   = 5'd31;
   localparam logic [REM_W-1:0]   REM_LAST       = 7'd99;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_SUB = 1'b1;

   // control from the sequencer to the year tracker
   typedef struct packed {
      logic load;      // take a new year, start the reciprocal product
      logic rem_step;  // finish year mod 100
      logic inc;
      logic dec;
   } yt_ctrl_type;

   // one month move proposed by the step unit
   typedef struct packed {
      logic                    done;
      logic                    oor;
      logic                    inc;
      logic                    dec;
      logic signed [ACC_W-1:0] day;
      logic [MONTH_W-1:0]      month;
   } step_type;

   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      begin
         unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
         endcase
         return len;
      end
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gds_year_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gds_year_tracker
// holds the working year with its residues mod 100 and 400, gives leap flag
// ----------------------------------------------------------------------------
module gds_year_tracker (
   input  wire logic                         clock,
   input  wire gds_pkg::yt_ctrl_type         ctrl,
   input  wire logic [gds_pkg::YEAR_W-1:0]   year_load,
   output logic      [gds_pkg::YEAR_W-1:0]   year,
   output logic                              leap
);

   logic [gds_pkg::YEAR_W-1:0] year_ff, year_in;
   logic [gds_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [gds_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [1:0]                 qlo_ff, qlo_in;
   logic [gds_pkg::YEAR_W-1:0] quot;
   logic [gds_pkg::YEAR_W-1:0] rem_wide;

   // floor(year * 5243 / 2^19) equals year / 100 for years up to 43698, not over the whole 16-bit range
   assign quot = gds_pkg::YEAR_W'(prod_ff[gds_pkg::PROD_W-1:gds_pkg::RECIP_SHIFT]);
   assign rem_wide = year_ff - gds_pkg::YEAR_W'(quot * 16'd100);

   always_comb begin
      year_in = year_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      qlo_in  = qlo_ff;
      priority if (ctrl.load) begin
         year_in = year_load;
         prod_in = gds_pkg::PROD_W'(year_load) * gds_pkg::PROD_W'(gds_pkg::RECIP_100);
      end else if (ctrl.rem_step) begin
         rem_in = rem_wide[gds_pkg::REM_W-1:0];
         qlo_in = quot[1:0];
      end else if (ctrl.inc) begin
         year_in = year_ff + 16'd1;
         if (rem_ff == gds_pkg::REM_LAST) begin
            rem_in = '0;
            qlo_in = qlo_ff + 2'd1;
         end else begin
            rem_in = rem_ff + 7'd1;
         end
      end else if (ctrl.dec) begin
         year_in = year_ff - 16'd1;
         if (rem_ff == '0) begin
            rem_in = gds_pkg::REM_LAST;
            qlo_in = qlo_ff - 2'd1;
         end else begin
            rem_in = rem_ff - 7'd1;
         end
      end else begin
         // no control this cycle, everything holds
      end
   end

   always_ff @(posedge clock) begin
      year_ff <= year_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      qlo_ff  <= qlo_in;
   end

   assign year = year_ff;
   // century years are leap only when year / 100 is a multiple of 4
   assign leap = (rem_ff != '0) ? (year_ff[1:0] == 2'd0) : (qlo_ff == 2'd0);

endmodule
`default_nettype wire

>>> hw/rtl/gds_month_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gds_month_step
// shared step unit: moves the working date by one month forward or back
// ----------------------------------------------------------------------------
module gds_month_step (
   input  wire logic                              mode,
   input  wire logic signed [gds_pkg::ACC_W-1:0]  day,
   input  wire logic        [gds_pkg::MONTH_W-1:0] month,
   input  wire logic        [gds_pkg::YEAR_W-1:0]  year,
   input  wire logic                              leap,
   output gds_pkg::step_type                      step
);

   logic [gds_pkg::DAY_W-1:0]   len;
   logic [gds_pkg::MONTH_W-1:0] m_sel;
   logic                        wrap;
   logic signed [gds_pkg::ACC_W-1:0] len_s;
   logic signed [gds_pkg::ACC_W-1:0] one_s;

   assign wrap  = (mode == gds_pkg::MODE_ADD) ? (month == gds_pkg::MONTH_DEC)
                                              : (month == gds_pkg::MONTH_JAN);
   // backward move reads the length of the previous month, December on a wrap
   assign m_sel = (mode == gds_pkg::MODE_ADD) ? month
                : (wrap ? gds_pkg::MONTH_DEC : month - 4'd1);
   assign len   = gds_pkg::month_days(leap, m_sel);
   assign len_s = $signed({{(gds_pkg::ACC_W-gds_pkg::DAY_W){1'b0}}, len});
   assign one_s = $signed(gds_pkg::ACC_W'(1));

   always_comb begin
      step.done  = 1'b0;
      step.oor   = 1'b0;
      step.inc   = 1'b0;
      step.dec   = 1'b0;
      step.day   = day;
      step.month = month;
      if (mode == gds_pkg::MODE_ADD) begin
         if (day > len_s) begin
            if (wrap && year == gds_pkg::YEAR_LAST) begin
               step.done  = 1'b1;
               step.oor   = 1'b1;
               step.day   = $signed(gds_pkg::ACC_W'(gds_pkg::DAY_LAST_DEC));
               step.month = gds_pkg::MONTH_DEC;
            end else begin
               step.day   = day - len_s;
               step.month = wrap ? gds_pkg::MONTH_JAN : month + 4'd1;
               step.inc   = wrap;
            end
         end else begin
            step.done = 1'b1;
         end
      end else begin
         if (day < one_s) begin
            if (wrap && year == '0) begin
               step.done  = 1'b1;
               step.oor   = 1'b1;
               step.day   = $signed(gds_pkg::ACC_W'(gds_pkg::DAY_FIRST));
               step.month = gds_pkg::MONTH_JAN;
            end else begin
               step.day   = day + len_s;
               step.month = m_sel;
               step.dec   = wrap;
            end
         end else begin
            step.done = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/gregorian_date_shift_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_shift_unit
// throughput: one request at a time; the month walk, one month per cycle
//   through the shared step unit, sets the rate; a response not yet taken holds the unit
// reset: control state clears, min_year returns to 1601, no response pending
// ----------------------------------------------------------------------------
// Moves a Gregorian date by a day count. After the request is taken, the year
// tracker finds year mod 100 by a reciprocal product, the start date is checked,
// and the day count is folded into a signed day accumulator. The step unit then
// walks one month per cycle until the accumulator lies inside the month or the year range ends.
// ----------------------------------------------------------------------------
module gregorian_date_shift_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [gds_pkg::YEAR_W-1:0]      csr_wdata,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_mode,
   input  wire logic [gds_pkg::DAY_W-1:0]       req_day,
   input  wire logic [gds_pkg::MONTH_W-1:0]     req_month,
   input  wire logic [gds_pkg::YEAR_W-1:0]      req_year,
   input  wire logic [gds_pkg::CNT_W-1:0]       req_day_count,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [gds_pkg::DAY_W-1:0]       rsp_new_day,
   output logic      [gds_pkg::MONTH_W-1:0]     rsp_new_month,
   output logic      [gds_pkg::YEAR_W-1:0]      rsp_new_year,
   output logic                                 rsp_input_invalid,
   output logic                                 rsp_out_of_range
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_REM   = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   localparam int ACC_W = gds_pkg::ACC_W;

   logic [2:0] state_ff, state_in;

   // configuration register
   logic [gds_pkg::YEAR_W-1:0] min_year_ff, min_year_in;

   // working date
   logic                              mode_ff, mode_in;
   logic signed [ACC_W-1:0]           acc_ff, acc_in;
   logic [gds_pkg::MONTH_W-1:0]       month_ff, month_in;
   logic [gds_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                              bad_ff, bad_in;
   logic                              oor_ff, oor_in;

   // response holding register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gds_pkg::DAY_W-1:0]         rsp_day_ff, rsp_day_in;
   logic [gds_pkg::MONTH_W-1:0]       rsp_month_ff, rsp_month_in;
   logic [gds_pkg::YEAR_W-1:0]        rsp_year_ff, rsp_year_in;
   logic                              rsp_bad_ff, rsp_bad_in;
   logic                              rsp_oor_ff, rsp_oor_in;

   gds_pkg::yt_ctrl_type              yt_ctrl;
   logic [gds_pkg::YEAR_W-1:0]        year;
   logic                              leap;
   gds_pkg::step_type                 step;

   logic                              accept;
   logic                              date_ok;
   logic [gds_pkg::DAY_W-1:0]         day_lo;
   logic signed [ACC_W-1:0]           count_s;

   assign accept  = req_valid && req_ready;
   assign day_lo  = acc_ff[gds_pkg::DAY_W-1:0];
   assign count_s = $signed({{(ACC_W-gds_pkg::CNT_W){1'b0}}, count_ff});

   // start date check, acc still holds the raw day here
   assign date_ok = (year >= min_year_ff)
                 && (month_ff >= gds_pkg::MONTH_JAN) && (month_ff <= gds_pkg::MONTH_DEC)
                 && (day_lo != '0)
                 && (day_lo <= gds_pkg::month_days(leap, month_ff));

   gds_year_tracker u_year (
      .clock     (clock),
      .ctrl      (yt_ctrl),
      .year_load (req_year),
      .year      (year),
      .leap      (leap)
   );

   gds_month_step u_step (
      .mode  (mode_ff),
      .day   (acc_ff),
      .month (month_ff),
      .year  (year),
      .leap  (leap),
      .step  (step)
   );

   always_comb begin
      state_in     = state_ff;
      min_year_in  = csr_we ? csr_wdata : min_year_ff;
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      month_in     = month_ff;
      count_in     = count_ff;
      bad_in       = bad_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_oor_in   = rsp_oor_ff;
      yt_ctrl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               yt_ctrl.load = 1'b1;
               mode_in  = req_mode;
               acc_in   = $signed({{(ACC_W-gds_pkg::DAY_W){1'b0}}, req_day});
               month_in = req_month;
               count_in = req_day_count;
               bad_in   = 1'b0;
               oor_in   = 1'b0;
               state_in = ST_REM;
            end
         end
         ST_REM: begin
            yt_ctrl.rem_step = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!date_ok) begin
               // invalid start date, echo it back
               bad_in   = 1'b1;
               state_in = ST_EMIT;
            end else begin
               acc_in   = (mode_ff == gds_pkg::MODE_ADD) ? acc_ff + count_s
                                                         : acc_ff - count_s;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            acc_in      = step.day;
            month_in    = step.month;
            oor_in      = step.oor;
            yt_ctrl.inc = step.inc;
            yt_ctrl.dec = step.dec;
            if (step.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the holding register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_day_in   = day_lo;
               rsp_month_in = month_ff;
               rsp_year_in  = year;
               rsp_bad_in   = bad_ff;
               rsp_oor_in   = oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_year_ff  <= gds_pkg::MIN_YEAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_year_ff  <= min_year_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      acc_ff       <= acc_in;
      month_ff     <= month_in;
      count_ff     <= count_in;
      bad_ff       <= bad_in;
      oor_ff       <= oor_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_day       = rsp_day_ff;
   assign rsp_new_month     = rsp_month_ff;
   assign rsp_new_year      = rsp_year_ff;
   assign rsp_input_invalid = rsp_bad_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

endmodule
`default_nettype wire
